FILE: src/integer_to_ascii_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_converter_unit assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_CONVERTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_CONVERTER_UNIT_ASSERT_SVH

// consequent holds in the same cycle
`define ITOA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// consequent holds in the next cycle
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`endif

FILE: src/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// types, constants and helpers shared by the integer to ascii converter
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W         = 64;
  localparam int DIGIT_W         = 4;
  localparam int DEC_DIGITS      = 20;
  localparam int BCD_W           = DEC_DIGITS * DIGIT_W;
  localparam int DIGIT_IDX_W     = 5;
  localparam int CONV_CNT_W      = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] MODE_SDEC    = 2'd0;
  localparam logic [1:0] MODE_UDEC32  = 2'd1;
  localparam logic [1:0] MODE_HEX_LO  = 2'd2;
  localparam logic [1:0] MODE_HEX_UP  = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         mode;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               hex;
    logic               upper;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_FIND,
    B_SIGN,
    B_EMIT
  } back_state_t;

  // ascii for one digit, hex letters in the chosen case
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

  // shift-add-3 correction on every bcd digit
  function automatic logic [BCD_W-1:0] bcd_fix(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        res[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    bcd_fix = res;
  endfunction

endpackage

FILE: src/itoa_queue.sv
// ----------------------------------------------------------------------------
// itoa_queue
// small fifo of classified jobs between the front and back parts
// ----------------------------------------------------------------------------
module itoa_queue #(
  parameter int DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  itoa_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output itoa_pkg::job_t pop_data
);
  import itoa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// accepts input beats and turns value and mode into a magnitude job
// ----------------------------------------------------------------------------
module itoa_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  itoa_pkg::in_t  in_data,
  output logic           push_valid,
  input  logic           push_ready,
  output itoa_pkg::job_t push_data
);
  import itoa_pkg::*;

  logic sign_bit;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign sign_bit   = in_data.value[VALUE_W-1];

  always_comb begin
    push_data.mag   = in_data.value;
    push_data.neg   = 1'b0;
    push_data.hex   = 1'b0;
    push_data.upper = 1'b0;
    unique case (in_data.mode)
      MODE_SDEC: begin
        // unsigned negate, so the most negative value stays exact
        if (sign_bit) begin
          push_data.mag = ~in_data.value + 1'b1;
          push_data.neg = 1'b1;
        end
      end
      MODE_UDEC32: begin
        push_data.mag = {{(VALUE_W-32){1'b0}}, in_data.value[31:0]};
      end
      MODE_HEX_LO: begin
        push_data.hex = 1'b1;
      end
      MODE_HEX_UP: begin
        push_data.hex   = 1'b1;
        push_data.upper = 1'b1;
      end
      default: begin
        push_data.hex = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// shift-add-3 decimal conversion and msd-first character output
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  itoa_pkg::job_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output itoa_pkg::out_t out_data
);
  import itoa_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [VALUE_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_fixed;
  logic [CONV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [DIGIT_IDX_W-1:0] lead;
  logic                   neg_r, neg_nxt;
  logic                   upper_r, upper_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;
  logic                   load_ok;
  logic [DIGIT_W-1:0]     cur_digit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pop_ready = (state_r == B_IDLE);
  assign load_ok   = !out_valid_r || out_ready;
  assign bcd_fixed = bcd_fix(bcd_r);
  assign cur_digit = bcd_r[{idx_r, 2'b00} +: DIGIT_W];

  // highest nonzero digit, zero value keeps index 0
  always_comb begin
    lead = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] != '0) begin
        lead = DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          neg_nxt   = pop_data.neg;
          upper_nxt = pop_data.upper;
          if (pop_data.hex) begin
            bcd_nxt   = {{(BCD_W-VALUE_W){1'b0}}, pop_data.mag};
            state_nxt = B_FIND;
          end else begin
            bin_nxt   = pop_data.mag;
            bcd_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = B_CONV;
          end
        end
      end
      B_CONV: begin
        bcd_nxt = {bcd_fixed[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = B_FIND;
        end
      end
      B_FIND: begin
        idx_nxt   = lead;
        state_nxt = neg_r ? B_SIGN : B_EMIT;
      end
      B_SIGN: begin
        if (load_ok) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = CH_MINUS;
          out_data_nxt.last      = 1'b0;
          state_nxt              = B_EMIT;
        end
      end
      B_EMIT: begin
        if (load_ok) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = digit_char(cur_digit, upper_r);
          out_data_nxt.last      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/integer_to_ascii_converter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_converter_unit
// 64-bit value to ascii text, one character per output beat
// ----------------------------------------------------------------------------
// Each input beat yields its text most significant digit first, no leading
// zeros, last set on the final character. Decimal modes run one load, 64
// shift-add-3 steps of the bcd conversion unit and one leading-digit search;
// hex modes run one load and the same search. Both then emit one character per
// cycle while the output is taken, the minus sign included. The conversion
// unit handles one number at a time, so it sets the rate; a job queue of
// QUEUE_DEPTH entries lets the input side keep taking beats while it works,
// and an output register holds each character until it is taken.
module integer_to_ascii_converter_unit #(
  parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  itoa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output itoa_pkg::out_t out_data
);
  import itoa_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_data, pop_data;

  itoa_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "integer_to_ascii_converter_unit_assert.svh"

module itoa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input itoa_pkg::out_t out_data
);
  import itoa_pkg::*;

  logic is_digit, is_lower, is_upper, is_minus;

  assign is_digit = (out_data.character >= CH_ZERO) && (out_data.character <= CH_NINE);
  assign is_lower = (out_data.character >= CH_LA) && (out_data.character <= CH_LF);
  assign is_upper = (out_data.character >= CH_UA) && (out_data.character <= CH_UF);
  assign is_minus = (out_data.character == CH_MINUS);

  `ITOA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ITOA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `ITOA_ASSERT_NOW(a_char_set, out_valid, is_digit || is_lower || is_upper || is_minus)
  `ITOA_ASSERT_NOW(a_minus_not_last, out_valid && is_minus, !out_data.last)

endmodule

bind integer_to_ascii_converter_unit itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/itoa_text_checker.sv
// ----------------------------------------------------------------------------
// itoa_text_checker
// watches both channels of the integer to ascii converter, works out the
// text each accepted number should produce and compares it beat by beat
// ----------------------------------------------------------------------------
module itoa_text_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  itoa_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  itoa_pkg::out_t out_data,
  output int             error_count,
  output int             pending
);
  import itoa_pkg::*;

  out_t expected_chars[$];
  int   out_beats;

  initial begin
    error_count = 0;
    pending     = 0;
    out_beats   = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] output beat %0d: %s", $time, out_beats, what);
    error_count++;
  endtask

  // queues the characters of one number, most significant first
  function automatic void push_text(input in_t item);
    logic [63:0] mag;
    logic [63:0] rem;
    logic [7:0]  digits[20];
    logic [3:0]  nib;
    logic        neg;
    int          n;
    out_t        beat;
    mag = item.value;
    neg = 1'b0;
    n   = 0;
    case (item.mode)
      MODE_SDEC: begin
        if (mag[63]) begin
          neg = 1'b1;
          // the most negative value negates to itself, read as unsigned it is right
          mag = ~mag + 64'd1;
        end
      end
      MODE_UDEC32: mag = {32'd0, mag[31:0]};
      default: ;
    endcase
    do begin
      if (item.mode == MODE_SDEC || item.mode == MODE_UDEC32) begin
        rem       = mag % 64'd10;
        digits[n] = CH_ZERO + rem[7:0];
        mag       = mag / 64'd10;
      end else begin
        nib = mag[3:0];
        if (nib < 4'd10) begin
          digits[n] = CH_ZERO + {4'd0, nib};
        end else begin
          digits[n] = ((item.mode == MODE_HEX_UP) ? CH_UA : CH_LA) + {4'd0, nib - 4'd10};
        end
        mag = mag >> 4;
      end
      n++;
    end while (mag != 64'd0);
    if (neg) begin
      beat.character = CH_MINUS;
      beat.last      = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int i = n - 1; i >= 0; i--) begin
      beat.character = digits[i];
      beat.last      = (i == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : beat_check
    out_t want;
    if (rst_n) begin
      // output side first: a character can never come from a number taken in this cycle
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                    out_data.character, out_data.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.character !== want.character) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      out_data.character, want.character));
          end
          if (out_data.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", out_data.last, want.last));
          end
        end
        out_beats++;
      end
      if (in_valid && in_ready) begin
        push_text(in_data);
      end
      pending <= expected_chars.size();
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives numbers in all four print modes into the converter with random gaps
// and output stalls; the checker predicts the text and flags any difference
// ----------------------------------------------------------------------------
module tb;
  import itoa_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_ITEMS = 32;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   error_count;
  int   pending;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   quiet_cycles = 0;

  always #6 clk = ~clk;

  integer_to_ascii_converter_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  itoa_text_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .error_count(error_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ends the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_number(input logic [63:0] v, input logic [1:0] m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value: v, mode: m};
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the input back until every queued character has come out
  task automatic wait_text_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [63:0] v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_number(64'd0, MODE_SDEC);
    send_number(64'd0, MODE_UDEC32);
    send_number(64'd0, MODE_HEX_LO);
    send_number(64'd0, MODE_HEX_UP);
    send_number(64'h8000_0000_0000_0000, MODE_SDEC);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_SDEC);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_SDEC);
    send_number(64'hFFFF_FFFF_FFFF_FFF6, MODE_SDEC);
    send_number(64'd1, MODE_SDEC);
    send_number(64'd9, MODE_SDEC);
    send_number(64'd10, MODE_SDEC);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC32);
    send_number(64'hFFFF_FFFF_0000_0000, MODE_UDEC32);
    send_number(64'h1234_5678_8000_0000, MODE_UDEC32);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX_LO);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX_UP);
    send_number(64'h0123_4567_89AB_CDEF, MODE_HEX_LO);
    send_number(64'h0123_4567_89AB_CDEF, MODE_HEX_UP);
    send_number(64'hFEDC_BA98_7654_3210, MODE_HEX_UP);
    send_number(64'h8000_0000_0000_0000, MODE_HEX_LO);
    wait_text_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 73;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 73;
        end
        default: begin
          idle_pct  = 37;
          stall_pct <= 37;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        v = {$urandom, $urandom};
        // spread text lengths and signs, with some tiny values
        case ($urandom_range(3))
          0: v = v >> $urandom_range(63);
          1: v = -(v >> $urandom_range(63));
          2: v = 64'($urandom_range(20));
          default: ;
        endcase
        send_number(v, 2'($urandom_range(3)));
      end
      wait_text_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
